/* src/sha1d_pkg.sv */
// Shared types and constants for the SHA-1 digest block.
package sha1d_pkg;

    localparam int Sha1dLengthBits = 64;
    localparam int Sha1dQueueDepth = 4;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] InitH [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] RoundK0 = 32'h5A827999;
    localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

    // One queued message word, big-endian, and whether it closes the message.
    typedef struct packed {
        logic [31:0] word;
        logic        final_word;
    } t_q_entry;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* src/sha1d_fifo.sv */
// Short word queue between the byte front end and the compression engine.
module sha1d_fifo
    import sha1d_pkg::*;
#(
    parameter int DEPTH = Sha1dQueueDepth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_push_data,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_status o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_q_entry            r_mem [DEPTH];
    logic [PtrW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]     r_count, n_count;
    logic                do_push, do_pop;

    assign o_status.full  = (r_count == CntW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* src/sha1d_front.sv */
// Byte front end: takes requests, counts length, packs words and pads.
module sha1d_front
    import sha1d_pkg::*;
#(
    parameter int LENGTH_BITS = Sha1dLengthBits
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  logic [7:0] i_data_byte,
    input  logic      i_byte_present,
    input  logic      i_last,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_q_entry  o_push_data
);

    typedef enum logic [3:0] {
        F_IN   = 4'b0001,
        F_P80  = 4'b0010,
        F_ZERO = 4'b0100,
        F_LEN  = 4'b1000
    } t_front_state;

    t_front_state          r_state, n_state;
    logic [5:0]            r_pos, n_pos;       // byte position within block
    logic [23:0]           r_word, n_word;     // bytes gathered so far
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                  emit;
    logic [7:0]            emit_byte;
    logic                  final_byte;
    logic                  in_acc;
    logic [63:0]           len_shift;

    assign o_stall   = !((r_state == F_IN) && !i_q_status.full);
    assign in_acc    = i_valid && !o_stall;
    assign len_shift = 64'(r_len) << {r_pos[2:0], 3'b000};

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        emit       = 1'b0;
        emit_byte  = '0;
        final_byte = 1'b0;
        unique case (r_state)
            F_IN: begin
                if (in_acc) begin
                    if (i_byte_present) begin
                        emit      = 1'b1;
                        emit_byte = i_data_byte;
                        n_len     = r_len + LENGTH_BITS'(8);
                    end
                    if (i_last) begin
                        n_state = F_P80;
                    end
                end
            end
            F_P80: begin
                if (!i_q_status.full) begin
                    emit      = 1'b1;
                    emit_byte = PadByte;
                    n_state   = (r_pos == 6'd55) ? F_LEN : F_ZERO;
                end
            end
            F_ZERO: begin
                if (!i_q_status.full) begin
                    emit = 1'b1;
                    if (r_pos == 6'd55) begin
                        n_state = F_LEN;
                    end
                end
            end
            F_LEN: begin
                if (!i_q_status.full) begin
                    emit      = 1'b1;
                    emit_byte = len_shift[63:56];
                    if (r_pos == 6'd63) begin
                        final_byte = 1'b1;
                        n_len      = '0;
                        n_state    = F_IN;
                    end
                end
            end
            default: n_state = F_IN;
        endcase
    end

    always_comb begin
        n_pos  = r_pos;
        n_word = r_word;
        if (emit) begin
            n_pos  = r_pos + 1'b1;
            n_word = {r_word[15:0], emit_byte};
        end
    end

    assign o_push                 = emit && (r_pos[1:0] == 2'b11);
    assign o_push_data.word       = {r_word, emit_byte};
    assign o_push_data.final_word = final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IN;
            r_pos   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

/* src/sha1d_back.sv */
// Compression engine: schedule load, 80 rounds, chaining update, digest out.
module sha1d_back
    import sha1d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_entry    i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_h0,
    output logic [31:0] o_digest_h1,
    output logic [31:0] o_digest_h2,
    output logic [31:0] o_digest_h3,
    output logic [31:0] o_digest_h4
);

    typedef enum logic [2:0] {
        B_LOAD  = 3'b001,
        B_ROUND = 3'b010,
        B_DONE  = 3'b100
    } t_back_state;

    t_back_state r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_final;
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [5];
    logic [31:0] r_out [5];
    logic        r_out_valid;

    logic        shift_en;
    logic [31:0] shift_in;
    logic [31:0] sched_x;
    logic [31:0] f_val, k_val, tmp;
    logic [31:0] sums [5];
    logic        out_free;
    logic        load_start, out_load;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == B_LOAD) && !i_q_status.empty;

    assign sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    // Round function and constant by quarter.
    always_comb begin
        if (r_cnt < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = RoundK0;
        end else if (r_cnt < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = RoundK1;
        end else if (r_cnt < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = RoundK2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = RoundK3;
        end
    end

    assign tmp = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];

    assign sums[0] = r_h[0] + r_a;
    assign sums[1] = r_h[1] + r_b;
    assign sums[2] = r_h[2] + r_c;
    assign sums[3] = r_h[3] + r_d;
    assign sums[4] = r_h[4] + r_e;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        shift_en   = 1'b0;
        shift_in   = i_head.word;
        load_start = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            B_LOAD: begin
                if (o_pop) begin
                    shift_en = 1'b1;
                    if (r_cnt == 7'd15) begin
                        load_start = 1'b1;
                        n_cnt      = '0;
                        n_state    = B_ROUND;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            B_ROUND: begin
                shift_en = 1'b1;
                shift_in = {sched_x[30:0], sched_x[31]};
                if (r_cnt == 7'd79) begin
                    n_cnt   = '0;
                    n_state = B_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            B_DONE: begin
                if (!r_final) begin
                    n_state = B_LOAD;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_state  = B_LOAD;
                end
            end
            default: n_state = B_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= InitH[i];
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == B_DONE) begin
                if (!r_final) begin
                    for (int i = 0; i < 5; i++) begin
                        r_h[i] <= sums[i];
                    end
                end else if (out_load) begin
                    for (int i = 0; i < 5; i++) begin
                        r_h[i] <= InitH[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= shift_in;
        end
        if (load_start) begin
            r_final <= i_head.final_word;
            r_a     <= r_h[0];
            r_b     <= r_h[1];
            r_c     <= r_h[2];
            r_d     <= r_h[3];
            r_e     <= r_h[4];
        end else if (r_state == B_ROUND) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
        if (out_load) begin
            for (int i = 0; i < 5; i++) begin
                r_out[i] <= sums[i];
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_digest_h0 = r_out[0];
    assign o_digest_h1 = r_out[1];
    assign o_digest_h2 = r_out[2];
    assign o_digest_h3 = r_out[3];
    assign o_digest_h4 = r_out[4];

endmodule

/* src/sha1_digest.sv */
// SHA-1 digest top level: byte front end, word queue, compression engine.
//
// Input channel: one request per byte (i_data_byte, i_byte_present, i_last),
// taken on a rising edge with i_valid high and o_stall low. A request with
// i_byte_present low and i_last low changes nothing; i_last high closes the
// message (after its byte, if one is present), even for an empty message.
// Output channel: one request per message with the five digest words, held
// in an output register until taken (o_valid high, i_stall low).
// Flow: the front end takes one byte a cycle while the queue has room,
// packing four bytes into a word for a four-entry queue. The engine loads
// 16 words and then runs one round per cycle for 80 rounds plus one
// chaining update; the queue takes only 16 bytes meanwhile, so the input
// stalls while the queue is full. After the last request the front end
// writes padding and length one byte a cycle while the queue has room (up
// to 72 bytes, input stalled), so the digest appears after the padding and
// a final compression, later still while the receiver stalls.
// Reset (synchronous, active low) restores the initial chaining words and
// clears length, position and the output valid. While the receiver stalls
// the digest holds; the engine waits before overwriting it, and the input
// keeps flowing until the queue fills.
module sha1_digest
    import sha1d_pkg::*;
#(
    parameter int LENGTH_BITS = Sha1dLengthBits,
    parameter int QUEUE_DEPTH = Sha1dQueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_h0,
    output logic [31:0] o_digest_h1,
    output logic [31:0] o_digest_h2,
    output logic [31:0] o_digest_h3,
    output logic [31:0] o_digest_h4
);

    logic      q_push;
    logic      q_pop;
    t_q_entry  q_push_data;
    t_q_entry  q_head;
    t_q_status q_status;

    // Front end: length count, word packing, padding and length field.
    sha1d_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .i_q_status     (q_status),
        .o_push         (q_push),
        .o_push_data    (q_push_data)
    );

    sha1d_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    // Back end: schedule, rounds, chaining words, digest register.
    sha1d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_digest_h0 (o_digest_h0),
        .o_digest_h1 (o_digest_h1),
        .o_digest_h2 (o_digest_h2),
        .o_digest_h3 (o_digest_h3),
        .o_digest_h4 (o_digest_h4)
    );

endmodule

/* bench/testbench.sv */
// Self-checking regression bench for the byte-fed SHA-1 digest block.
`timescale 1ns / 1ps

module testbench;
    import sha1d_pkg::*;

    // Five digest words, index 0 is h0.
    typedef logic [4:0][31:0] t_digest;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_h0, o_digest_h1, o_digest_h2, o_digest_h3, o_digest_h4;

    sha1_digest i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_h0    (o_digest_h0),
        .o_digest_h1    (o_digest_h1),
        .o_digest_h2    (o_digest_h2),
        .o_digest_h3    (o_digest_h3),
        .o_digest_h4    (o_digest_h4)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hashing state of the predictor, kept apart from the block.
    logic [7:0]  msg_block [64];
    int unsigned msg_fill;
    logic [31:0] chain_h [5];
    logic [63:0] msg_bits;
    localparam logic [63:0] LenMask = {64{1'b1}} >> (64 - Sha1dLengthBits);

    t_digest     digest_queue [$];
    int          mismatch_count = 0;
    int          taken_items = 0;     // requests that carry a byte or close a message
    bit          idle_on = 1'b1;      // random gaps and receiver stalls enabled
    int          stall_left = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One 80-round compression of msg_block into chain_h.
    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16)
                w[t % 16] = rol32(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^
                                  w[(t + 2) % 16] ^ w[t % 16], 1);
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = RoundK0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = RoundK1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RoundK2;
            end else begin
                f = b ^ c ^ d;
                k = RoundK3;
            end
            tmp = rol32(a, 5) + f + e + k + w[t % 16];
            e = d; d = c; c = rol32(b, 30); b = a; a = tmp;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 5; i++)
            chain_h[i] = InitH[i];
        msg_fill = 0;
        msg_bits = '0;
    endfunction

    // Advance the predictor by one accepted request; a closing request queues a digest.
    function automatic void predict_digest(input logic [7:0] b, input logic p, input logic l);
        t_digest d;
        if (p) begin
            msg_block[msg_fill] = b;
            msg_fill++;
            msg_bits = (msg_bits + 64'd8) & LenMask;
            if (msg_fill == 64) begin
                sha1_compress();
                msg_fill = 0;
            end
        end
        if (!l)
            return;
        msg_block[msg_fill] = PadByte;
        msg_fill++;
        // No room for the length field: close this block and pad a fresh one.
        if (msg_fill > 56) begin
            for (int i = msg_fill; i < 64; i++)
                msg_block[i] = 8'h00;
            sha1_compress();
            msg_fill = 0;
        end
        for (int i = msg_fill; i < 56; i++)
            msg_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[56 + i] = msg_bits[63 - 8*i -: 8];
        sha1_compress();
        for (int i = 0; i < 5; i++)
            d[i] = chain_h[i];
        digest_queue.push_back(d);
        restart_message();
    endfunction

    // Present one request and hold it until taken. Valid stays high afterwards
    // so that back-to-back requests need no second assignment in one step.
    task automatic send_request(input logic [7:0] b, input logic p, input logic l);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= p;
        i_last         <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digest(b, p, l);
        if (p || l)
            taken_items++;
    endtask

    task automatic release_channel();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // A whole message of random bytes, with optional empty requests mixed in.
    // The last byte carries the closing flag about half the time; otherwise an
    // empty closing request follows.
    task automatic send_message(input int len, input bit noisy);
        bit close_on_byte;
        close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1,
                         close_on_byte && (i == len - 1));
        end
        if (!close_on_byte)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Empty message, extreme bytes, final byte carrying the flag, and empty requests.
    task automatic test_directed();
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b1);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h7F, 1'b0, 1'b0);
        send_request(8'h01, 1'b1, 1'b1);
    endtask

    // Lengths either side of the padding split and the block edge.
    task automatic test_boundary_lengths();
        int lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        foreach (lens[i])
            send_message(lens[i], 1'b1);
    endtask

    // Mostly short messages so that digests come often; now and then a long one.
    task automatic test_random_messages();
        int goal;
        goal = taken_items + 170;
        while (taken_items < goal) begin
            if ($urandom_range(0, 19) == 0)
                send_message($urandom_range(100, 200), 1'b1);
            else
                send_message($urandom_range(0, 24), 1'($urandom_range(0, 1)));
        end
    endtask

    // Sender holds off until every digest has come, then carries on.
    task automatic test_drain_pause();
        send_message($urandom_range(1, 40), 1'b0);
        release_channel();
        while (digest_queue.size() != 0) @(posedge i_clk);
        send_message(0, 1'b0);
        send_message($urandom_range(60, 70), 1'b1);
    endtask

    // Last stretch with no idling on either side.
    task automatic test_full_rate();
        int goal;
        idle_on = 1'b0;
        goal = taken_items + 100;
        while (taken_items < goal)
            send_message($urandom_range(0, 12), 1'b0);
    endtask

    // Receiver stall: bursts of random length between random runs of readiness.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end else begin
            i_stall    <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end
    end

    // Each digest taken is checked word by word against the oldest prediction.
    always @(posedge i_clk) begin
        t_digest want;
        t_digest seen;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = {o_digest_h4, o_digest_h3, o_digest_h2, o_digest_h1, o_digest_h0};
            if (digest_queue.size() == 0) begin
                report_mismatch($sformatf("digest %h with none predicted", seen));
            end else begin
                want = digest_queue.pop_front();
                for (int i = 0; i < 5; i++)
                    if (seen[i] !== want[i])
                        report_mismatch($sformatf("digest_h%0d got %h want %h",
                                                  i, seen[i], want[i]));
            end
        end
    end

    initial begin
        restart_message();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_boundary_lengths();
        test_random_messages();
        test_drain_pause();
        test_random_messages();
        test_full_rate();
        release_channel();

        // Let the padding and the final compression of the last message finish.
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("sha1_digest regression: pass");
        else
            $display("sha1_digest regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #20_000_000;
        $display("sha1_digest regression: fail");
        $finish;
    end

endmodule

/* sim.f */
src/sha1d_pkg.sv
src/sha1d_fifo.sv
src/sha1d_front.sv
src/sha1d_back.sv
src/sha1_digest.sv
bench/testbench.sv
